/* hdl/bfsa_pkg.sv */
// Shared types and constants for the best-fit segment allocator.
// No dependencies; every other file of the block imports this package.
package bfsa_pkg;

   localparam int MEM_UNITS_DEF = 2048;
   localparam int MAX_SEG_DEF   = 32;

   localparam int OWNER_W  = 8;
   localparam int REQ_W    = 12;
   localparam int STATUS_W = 2;
   localparam int ADDR_W   = 11;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_FULL    = 2'd2,
      ST_NOOWNER = 2'd3
   } status_type;

   // Table update broadcast to every cell
   typedef enum logic [1:0] {
      OP_NOP     = 2'd0,
      OP_ALLOC   = 2'd1,
      OP_RELEASE = 2'd2,
      OP_MERGE   = 2'd3
   } op_code_type;

   typedef struct packed {
      op_code_type          code;
      logic                 split;
      logic                 free_mode;
      logic [OWNER_W-1:0]   owner;
      logic [REQ_W-1:0]     req;
   } cell_op_type;

   // Flags of the search probe that walks down the chain
   typedef struct packed {
      logic found;
      logic prev_used;
      logic left_free;
      logic right_free;
      logic just_hit;
   } probe_flags_type;

endpackage

/* hdl/bfsa_if.sv */
// Request and response channel interfaces of the segment allocator.
// Depends on bfsa_pkg for field widths.
interface bfsa_req_if import bfsa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [OWNER_W-1:0] owner_id;
   logic [REQ_W-1:0]   req_size;

   modport source (output valid, cmd, owner_id, req_size, input ready);
   modport sink   (input valid, cmd, owner_id, req_size, output ready);
endinterface

interface bfsa_rsp_if import bfsa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   address;

   modport source (output valid, status, address, input ready);
   modport sink   (input valid, status, address, output ready);
endinterface

/* hdl/bfsa_cell.sv */
// One entry of the segment table plus one stage of the search probe.
// Depends on bfsa_pkg.
module bfsa_cell import bfsa_pkg::*; #(
   parameter int IDX        = 0,
   parameter int AW         = 11,
   parameter int SW         = 12,
   parameter int IW         = 5,
   parameter int CW         = 6,
   parameter int RESET_SIZE = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_op_type           op,
   input  logic [IW-1:0]         op_idx,
   input  logic                  live,
   input  logic [AW-1:0]         left_start,
   input  logic [SW-1:0]         left_size,
   input  logic [OWNER_W-1:0]    left_owner,
   input  logic                  left_used,
   input  logic [AW-1:0]         right_start,
   input  logic [SW-1:0]         right_size,
   input  logic [OWNER_W-1:0]    right_owner,
   input  logic                  right_used,
   input  probe_flags_type       pin_flags,
   input  logic [IW-1:0]         pin_idx,
   input  logic [SW-1:0]         pin_size,
   input  logic [AW-1:0]         pin_start,
   output probe_flags_type       pout_flags,
   output logic [IW-1:0]         pout_idx,
   output logic [SW-1:0]         pout_size,
   output logic [AW-1:0]         pout_start,
   output logic [AW-1:0]         seg_start,
   output logic [SW-1:0]         seg_size,
   output logic [OWNER_W-1:0]    seg_owner,
   output logic                  seg_used
);

   logic [AW-1:0]      start_ff, start_in;
   logic [SW-1:0]      size_ff, size_in;
   logic [OWNER_W-1:0] owner_ff, owner_in;
   logic               used_ff, used_in;

   probe_flags_type    pflags_ff, pflags_in;
   logic [IW-1:0]      pidx_ff, pidx_in;
   logic [SW-1:0]      psize_ff, psize_in;
   logic [AW-1:0]      pstart_ff, pstart_in;

   logic [CW-1:0] my_pos, at_idx, at_next;
   logic [SW-1:0] req_ext, split_start;

   assign my_pos  = CW'(IDX);
   assign at_idx  = CW'(op_idx);
   assign at_next = at_idx + CW'(1);
   assign req_ext = SW'(op.req);
   assign split_start = SW'(left_start) + req_ext;

   // Entry update
   always_comb begin
      start_in = start_ff;
      size_in  = size_ff;
      owner_in = owner_ff;
      used_in  = used_ff;
      case (op.code)
         OP_ALLOC: begin
            if (my_pos == at_idx) begin
               size_in  = req_ext;
               used_in  = 1'b1;
               owner_in = op.owner;
            end else if (op.split && my_pos == at_next) begin
               start_in = split_start[AW-1:0];
               size_in  = left_size - req_ext;
               used_in  = 1'b0;
               owner_in = '0;
            end else if (op.split && my_pos > at_next) begin
               start_in = left_start;
               size_in  = left_size;
               // owner and used come from the left neighbour
               owner_in = left_owner;
               used_in  = left_used;
            end
         end
         OP_RELEASE: begin
            if (my_pos == at_idx) begin
               used_in  = 1'b0;
               owner_in = '0;
            end
         end
         OP_MERGE: begin
            if (my_pos == at_idx) begin
               size_in = size_ff + right_size;
            end else if (my_pos > at_idx) begin
               start_in = right_start;
               size_in  = right_size;
               owner_in = right_owner;
               used_in  = right_used;
            end
         end
         default: begin
         end
      endcase
   end

   // Probe stage: best fit on allocate, first owner match on free
   always_comb begin
      pflags_in = pin_flags;
      pidx_in   = pin_idx;
      psize_in  = pin_size;
      pstart_in = pin_start;
      pflags_in.prev_used = used_ff;
      pflags_in.just_hit  = 1'b0;
      if (!op.free_mode) begin
         if (live && !used_ff && size_ff >= req_ext &&
             (!pin_flags.found || size_ff < pin_size)) begin
            pflags_in.found = 1'b1;
            pidx_in   = IW'(IDX);
            psize_in  = size_ff;
            pstart_in = start_ff;
         end
      end else begin
         if (pin_flags.just_hit) begin
            pflags_in.right_free = live && !used_ff;
         end
         if (live && used_ff && owner_ff == op.owner && !pin_flags.found) begin
            pflags_in.found     = 1'b1;
            pflags_in.just_hit  = 1'b1;
            pflags_in.left_free = !pin_flags.prev_used;
            pidx_in   = IW'(IDX);
            psize_in  = size_ff;
            pstart_in = start_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         size_ff  <= SW'(RESET_SIZE);
         owner_ff <= '0;
         used_ff  <= 1'b0;
      end else begin
         start_ff <= start_in;
         size_ff  <= size_in;
         owner_ff <= owner_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      pflags_ff <= pflags_in;
      pidx_ff   <= pidx_in;
      psize_ff  <= psize_in;
      pstart_ff <= pstart_in;
   end

   assign pout_flags = pflags_ff;
   assign pout_idx   = pidx_ff;
   assign pout_size  = psize_ff;
   assign pout_start = pstart_ff;
   assign seg_start  = start_ff;
   assign seg_size   = size_ff;
   assign seg_owner  = owner_ff;
   assign seg_used   = used_ff;

endmodule

/* hdl/best_fit_segment_allocator_unit.sv */
// Top level of the best-fit segment allocator: control sequencer and cell chain.
// Depends on bfsa_pkg, bfsa_if and bfsa_cell.

// Each request runs through a row of MAX_SEGMENTS cells, one table entry per
// cell. A search probe enters the first cell and moves one cell per clock. A
// request is taken in idle and the probe then searches the chain; the table is
// updated at the end of the search, split and shift included. A freed segment
// is then merged with its free neighbours in S_MERGE_R and S_MERGE_L, and the
// response register is loaded in S_DONE once it is empty or being read. An
// allocate of zero units skips the search and answers ST_NOFIT. One request is
// worked on at a time; the next is taken while a response still waits in the
// output register.
module best_fit_segment_allocator_unit import bfsa_pkg::*; #(
   parameter int MEM_UNITS    = MEM_UNITS_DEF,
   parameter int MAX_SEGMENTS = MAX_SEG_DEF
) (
   input  logic        clock,
   input  logic        reset,
   bfsa_req_if.sink    req_chan,
   bfsa_rsp_if.source  rsp_chan
);

   localparam int AW0 = $clog2(MEM_UNITS);
   localparam int SW0 = $clog2(MEM_UNITS + 1);
   localparam int AW  = (AW0 < 1) ? 1 : AW0;
   localparam int SW  = (SW0 > REQ_W) ? SW0 : REQ_W;
   localparam int IW  = $clog2(MAX_SEGMENTS);
   localparam int CW  = $clog2(MAX_SEGMENTS + 1);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_SCAN    = 6'b000010,
      S_MERGE_R = 6'b000100,
      S_MERGE_L = 6'b001000,
      S_DONE    = 6'b010000,
      S_SPARE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic               cmd_ff, cmd_in;
   logic [OWNER_W-1:0] owner_ff, owner_in;
   logic [REQ_W-1:0]   req_ff, req_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [IW-1:0]      hit_ff, hit_in;
   logic               lfree_ff, lfree_in;
   status_type         res_status_ff, res_status_in;
   logic [AW-1:0]      res_addr_ff, res_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;

   cell_op_type        op;
   logic [IW-1:0]      op_idx;

   // Per-cell wiring, each element used at its own fixed place
   logic [AW-1:0]      e_start [MAX_SEGMENTS];
   logic [SW-1:0]      e_size  [MAX_SEGMENTS];
   logic [OWNER_W-1:0] e_owner [MAX_SEGMENTS];
   logic               e_used  [MAX_SEGMENTS];
   probe_flags_type    p_flags [MAX_SEGMENTS];
   logic [IW-1:0]      p_idx   [MAX_SEGMENTS];
   logic [SW-1:0]      p_size  [MAX_SEGMENTS];
   logic [AW-1:0]      p_start [MAX_SEGMENTS];

   probe_flags_type    init_flags;
   logic               inject;
   probe_flags_type    last_flags;
   logic [SW-1:0]      rest;
   logic [AW+ADDR_W-1:0] addr_wide;

   assign inject = (state_ff == S_SCAN) && (cnt_ff == '0);

   // Probe entering cell zero: nothing found, no free left neighbour
   always_comb begin
      init_flags = '0;
      init_flags.prev_used = 1'b1;
   end

   // Cell chain
   for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
      probe_flags_type    in_flags;
      logic [IW-1:0]      in_idx;
      logic [SW-1:0]      in_size;
      logic [AW-1:0]      in_start;
      logic [AW-1:0]      l_start, r_start;
      logic [SW-1:0]      l_size, r_size;
      logic [OWNER_W-1:0] l_owner, r_owner;
      logic               l_used, r_used;
      logic               live;

      assign live = CW'(k) < count_ff;

      if (k == 0) begin : g_first
         assign in_flags = inject ? init_flags : '0;
         assign in_idx   = '0;
         assign in_size  = '0;
         assign in_start = '0;
         assign l_start  = '0;
         assign l_size   = '0;
         assign l_owner  = '0;
         assign l_used   = 1'b0;
      end else begin : g_rest
         assign in_flags = p_flags[k-1];
         assign in_idx   = p_idx[k-1];
         assign in_size  = p_size[k-1];
         assign in_start = p_start[k-1];
         assign l_start  = e_start[k-1];
         assign l_size   = e_size[k-1];
         assign l_owner  = e_owner[k-1];
         assign l_used   = e_used[k-1];
      end

      if (k == MAX_SEGMENTS - 1) begin : g_last
         assign r_start = '0;
         assign r_size  = '0;
         assign r_owner = '0;
         assign r_used  = 1'b0;
      end else begin : g_mid
         assign r_start = e_start[k+1];
         assign r_size  = e_size[k+1];
         assign r_owner = e_owner[k+1];
         assign r_used  = e_used[k+1];
      end

      bfsa_cell #(
         .IDX        (k),
         .AW         (AW),
         .SW         (SW),
         .IW         (IW),
         .CW         (CW),
         .RESET_SIZE ((k == 0) ? MEM_UNITS : 0)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op),
         .op_idx      (op_idx),
         .live        (live),
         .left_start  (l_start),
         .left_size   (l_size),
         .left_owner  (l_owner),
         .left_used   (l_used),
         .right_start (r_start),
         .right_size  (r_size),
         .right_owner (r_owner),
         .right_used  (r_used),
         .pin_flags   (in_flags),
         .pin_idx     (in_idx),
         .pin_size    (in_size),
         .pin_start   (in_start),
         .pout_flags  (p_flags[k]),
         .pout_idx    (p_idx[k]),
         .pout_size   (p_size[k]),
         .pout_start  (p_start[k]),
         .seg_start   (e_start[k]),
         .seg_size    (e_size[k]),
         .seg_owner   (e_owner[k]),
         .seg_used    (e_used[k])
      );
   end

   assign last_flags = p_flags[MAX_SEGMENTS-1];
   assign rest       = p_size[MAX_SEGMENTS-1] - SW'(req_ff);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      owner_in      = owner_ff;
      req_in        = req_ff;
      count_in      = count_ff;
      cnt_in        = cnt_ff;
      hit_in        = hit_ff;
      lfree_in      = lfree_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      op            = '0;
      op.code       = OP_NOP;
      op.free_mode  = cmd_ff;
      op.owner      = owner_ff;
      op.req        = req_ff;
      op_idx        = hit_ff;
      req_chan.ready = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               cmd_in   = req_chan.cmd;
               owner_in = req_chan.owner_id;
               req_in   = req_chan.req_size;
               cnt_in   = '0;
               res_addr_in = '0;
               if (req_chan.cmd == CMD_ALLOC && req_chan.req_size == '0) begin
                  res_status_in = ST_NOFIT;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (cnt_ff != CW'(MAX_SEGMENTS)) begin
               cnt_in = cnt_ff + CW'(1);
            end else begin
               hit_in   = p_idx[MAX_SEGMENTS-1];
               lfree_in = last_flags.left_free;
               op_idx   = p_idx[MAX_SEGMENTS-1];
               state_in = S_DONE;
               if (cmd_ff == CMD_ALLOC) begin
                  if (!last_flags.found) begin
                     res_status_in = ST_NOFIT;
                  end else if (rest != '0 && count_ff == CW'(MAX_SEGMENTS)) begin
                     res_status_in = ST_FULL;
                  end else begin
                     op.code       = OP_ALLOC;
                     op.split      = (rest != '0);
                     count_in      = count_ff + CW'(rest != '0);
                     res_status_in = ST_DONE;
                     res_addr_in   = p_start[MAX_SEGMENTS-1];
                  end
               end else begin
                  if (!last_flags.found) begin
                     res_status_in = ST_NOOWNER;
                  end else begin
                     op.code       = OP_RELEASE;
                     res_status_in = ST_DONE;
                     if (last_flags.right_free) begin
                        state_in = S_MERGE_R;
                     end else if (last_flags.left_free) begin
                        state_in = S_MERGE_L;
                     end
                  end
               end
            end
         end
         S_MERGE_R: begin
            op.code  = OP_MERGE;
            count_in = count_ff - CW'(1);
            state_in = lfree_ff ? S_MERGE_L : S_DONE;
         end
         S_MERGE_L: begin
            op.code  = OP_MERGE;
            op_idx   = hit_ff - IW'(1);
            count_in = count_ff - CW'(1);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = addr_wide[ADDR_W-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign addr_wide = {{ADDR_W{1'b0}}, res_addr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CW'(1);
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      owner_ff      <= owner_in;
      req_ff        <= req_in;
      hit_ff        <= hit_in;
      lfree_ff      <= lfree_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.status  = rsp_status_ff;
   assign rsp_chan.address = rsp_addr_ff;

endmodule
